[rtl/biou_pkg.sv]
`timescale 1ns / 1ps
// shared types, widths and the restoring division step for the box iou pipeline
// depends on nothing; used by the geometry, divider and top level
package biou_pkg;

    localparam int SIZE_BITS  = 15;
    localparam int FIELD_BITS = 16;
    localparam int AREA_BITS  = 2 * SIZE_BITS;
    localparam int UNI_BITS   = AREA_BITS + 1;
    localparam int RATIO_BITS = 16;

    typedef struct packed {
        logic [FIELD_BITS-1:0] first_x;
        logic [FIELD_BITS-1:0] first_y;
        logic [SIZE_BITS-1:0]  first_width;
        logic [SIZE_BITS-1:0]  first_height;
        logic [FIELD_BITS-1:0] second_x;
        logic [FIELD_BITS-1:0] second_y;
        logic [SIZE_BITS-1:0]  second_width;
        logic [SIZE_BITS-1:0]  second_height;
    } t_box_pair;

    typedef struct packed {
        logic [RATIO_BITS-1:0] overlap_ratio;
        logic                  empty_union;
    } t_iou_result;

    // overlap area and sum of both box areas
    typedef struct packed {
        logic [AREA_BITS-1:0] inter;
        logic [UNI_BITS-1:0]  sum;
    } t_area_pair;

    typedef struct packed {
        logic                qbit;
        logic [UNI_BITS-1:0] rem;
    } t_div_step;

    // one restoring step: double the remainder, subtract the divisor if it fits
    function automatic t_div_step div_step(input logic [UNI_BITS-1:0] rem,
                                           input logic [UNI_BITS-1:0] dvs);
        logic [UNI_BITS:0] two_r;
        logic [UNI_BITS:0] diff;
        t_div_step         res;
        two_r = {rem, 1'b0};
        diff  = two_r - {1'b0, dvs};
        if (two_r >= {1'b0, dvs}) begin
            res.qbit = 1'b1;
            res.rem  = diff[UNI_BITS-1:0];
        end else begin
            res.qbit = 1'b0;
            res.rem  = two_r[UNI_BITS-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/biou_stream_if.sv]
`timescale 1ns / 1ps
// valid/ready stream channel carrying one payload of type T
interface biou_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/biou_geom.sv]
`timescale 1ns / 1ps
// three-stage front end: overlap edges and box areas, overlap lengths and area sum, overlap area
// depends on biou_pkg
module biou_geom #(
    parameter int COORD_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  biou_pkg::t_box_pair    i_pair,
    output logic                   o_valid,
    input  logic                   i_ready,
    output biou_pkg::t_area_pair   o_area
);

    localparam int CW = COORD_BITS;
    localparam int EW = ((CW > biou_pkg::FIELD_BITS) ? CW : biou_pkg::FIELD_BITS) + 2;
    localparam int SB = biou_pkg::SIZE_BITS;
    localparam int AB = biou_pkg::AREA_BITS;
    localparam int UB = biou_pkg::UNI_BITS;

    logic signed [EW-1:0] ax, ay, bx, by;
    logic signed [EW-1:0] aw, ah, bw, bh;

    // coordinate from its low COORD_BITS bits; wider settings see the field as unsigned
    generate
        if (CW <= biou_pkg::FIELD_BITS) begin : g_coord_signed
            assign ax = EW'($signed(i_pair.first_x[CW-1:0]));
            assign ay = EW'($signed(i_pair.first_y[CW-1:0]));
            assign bx = EW'($signed(i_pair.second_x[CW-1:0]));
            assign by = EW'($signed(i_pair.second_y[CW-1:0]));
        end else begin : g_coord_wide
            assign ax = EW'($signed({1'b0, i_pair.first_x}));
            assign ay = EW'($signed({1'b0, i_pair.first_y}));
            assign bx = EW'($signed({1'b0, i_pair.second_x}));
            assign by = EW'($signed({1'b0, i_pair.second_y}));
        end
    endgenerate

    assign aw = EW'($signed({1'b0, i_pair.first_width}));
    assign ah = EW'($signed({1'b0, i_pair.first_height}));
    assign bw = EW'($signed({1'b0, i_pair.second_width}));
    assign bh = EW'($signed({1'b0, i_pair.second_height}));

    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;

    // stage 1: overlap edges and both areas
    logic signed [EW-1:0] n_lo_x, n_hi_x, n_lo_y, n_hi_y;
    logic signed [EW-1:0] ea_x, eb_x, ea_y, eb_y;
    logic signed [EW-1:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic [AB-1:0]        r_area_a, r_area_b;

    // stage 2: overlap lengths and area sum
    logic signed [EW:0]   dx, dy;
    logic [SB-1:0]        n_iw, n_ih;
    logic [SB-1:0]        r_iw, r_ih;
    logic [UB-1:0]        r_sum2;

    // stage 3: overlap area
    logic [AB-1:0]        r_inter;
    logic [UB-1:0]        r_sum3;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_comb begin
        ea_x   = ax + aw;
        eb_x   = bx + bw;
        ea_y   = ay + ah;
        eb_y   = by + bh;
        n_lo_x = (ax > bx) ? ax : bx;
        n_hi_x = (ea_x < eb_x) ? ea_x : eb_x;
        n_lo_y = (ay > by) ? ay : by;
        n_hi_y = (ea_y < eb_y) ? ea_y : eb_y;
    end

    always_comb begin
        dx   = (EW+1)'(r_hi_x) - (EW+1)'(r_lo_x);
        dy   = (EW+1)'(r_hi_y) - (EW+1)'(r_lo_y);
        n_iw = (dx > 0) ? dx[SB-1:0] : '0;
        n_ih = (dy > 0) ? dy[SB-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_lo_x   <= n_lo_x;
            r_hi_x   <= n_hi_x;
            r_lo_y   <= n_lo_y;
            r_hi_y   <= n_hi_y;
            r_area_a <= AB'(i_pair.first_width) * AB'(i_pair.first_height);
            r_area_b <= AB'(i_pair.second_width) * AB'(i_pair.second_height);
        end
        if (en2) begin
            r_iw   <= n_iw;
            r_ih   <= n_ih;
            r_sum2 <= UB'(r_area_a) + UB'(r_area_b);
        end
        if (en3) begin
            r_inter <= AB'(r_iw) * AB'(r_ih);
            r_sum3  <= r_sum2;
        end
    end

    assign o_valid      = r_v3;
    assign o_area.inter = r_inter;
    assign o_area.sum   = r_sum3;

    // the overlap lies inside both boxes, so twice its area never passes the sum
    a_inter_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ({r_inter, 1'b0} <= r_sum3))
        else $error("overlap area exceeds half the area sum");

    // a stalled output keeps its transfer unchanged
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_area)))
        else $error("geometry output changed while stalled");

    // an empty last stage never blocks the input
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |-> o_ready)
        else $error("geometry not ready with an empty last stage");

endmodule

[rtl/biou_div.sv]
`timescale 1ns / 1ps
// pipelined restoring divider: overlap over union, two quotient bits per stage,
// then saturation and the empty-union flag; depends on biou_pkg
module biou_div #(
    parameter int FRAC_BITS = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  biou_pkg::t_area_pair  i_area,
    output logic                  o_valid,
    input  logic                  i_ready,
    output biou_pkg::t_iou_result o_result
);

    localparam int UB    = biou_pkg::UNI_BITS;
    localparam int RB    = biou_pkg::RATIO_BITS;
    localparam int QW    = FRAC_BITS + 1;
    localparam int STEPS = 2;
    localparam int NS    = (FRAC_BITS + STEPS - 1) / STEPS;

    // stage 0 holds the divisor setup, stages 1..NS each retire up to STEPS quotient bits
    logic [NS:0]   r_vld;
    logic [NS:0]   en;
    logic [UB-1:0] r_rem [0:NS];
    logic [UB-1:0] r_uni [0:NS];
    logic [QW-1:0] r_quo [0:NS];
    logic          r_emp [0:NS];

    logic [UB-1:0] n_rem [1:NS];
    logic [QW-1:0] n_quo [1:NS];

    logic          en_out;
    logic          r_out_vld;
    logic [RB-1:0] r_out_ratio;
    logic          r_out_empty;
    logic [RB-1:0] n_ratio;

    logic          n_q0;
    logic [UB-1:0] n_uni0;

    always_comb begin
        en_out = !r_out_vld || i_ready;
        en[NS] = !r_vld[NS] || en_out;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end
    assign o_ready = en[0];

    // the top quotient bit is set only when overlap equals union
    assign n_q0   = (i_area.sum == {i_area.inter, 1'b0});
    assign n_uni0 = i_area.sum - UB'(i_area.inter);

    always_comb begin
        logic [UB-1:0]       rem;
        logic [QW-1:0]       quo;
        biou_pkg::t_div_step st;
        for (int k = 1; k <= NS; k++) begin
            rem = r_rem[k-1];
            quo = r_quo[k-1];
            for (int s = 0; s < STEPS; s++) begin
                if ((k - 1) * STEPS + s < FRAC_BITS) begin
                    st  = biou_pkg::div_step(rem, r_uni[k-1]);
                    rem = st.rem;
                    quo = {quo[QW-2:0], st.qbit};
                end
            end
            n_rem[k] = rem;
            n_quo[k] = quo;
        end
    end

    generate
        if (QW > RB) begin : g_sat
            always_comb begin
                if (r_emp[NS]) begin
                    n_ratio = '0;
                end else if (|r_quo[NS][QW-1:RB]) begin
                    n_ratio = '1;
                end else begin
                    n_ratio = r_quo[NS][RB-1:0];
                end
            end
        end else begin : g_nosat
            always_comb begin
                if (r_emp[NS]) begin
                    n_ratio = '0;
                end else begin
                    n_ratio = RB'(r_quo[NS]);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k <= NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
            if (en_out) r_out_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem[0] <= n_q0 ? '0 : UB'(i_area.inter);
            r_uni[0] <= n_uni0;
            r_quo[0] <= QW'(n_q0);
            r_emp[0] <= (i_area.sum == '0);
        end
        for (int k = 1; k <= NS; k++) begin
            if (en[k]) begin
                r_rem[k] <= n_rem[k];
                r_uni[k] <= r_uni[k-1];
                r_quo[k] <= n_quo[k];
                r_emp[k] <= r_emp[k-1];
            end
        end
        if (en_out) begin
            r_out_ratio <= n_ratio;
            r_out_empty <= r_emp[NS];
        end
    end

    assign o_valid                = r_out_vld;
    assign o_result.overlap_ratio = r_out_ratio;
    assign o_result.empty_union   = r_out_empty;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS] && !r_emp[NS]) |-> (r_rem[NS] < r_uni[NS]))
        else $error("division remainder not below the union");

    a_empty_forces_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_empty) |-> (r_out_ratio == '0))
        else $error("empty union with nonzero ratio");

    a_empty_from_stage0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && r_emp[0]) |-> (r_uni[0] == '0 && r_rem[0] == '0))
        else $error("empty union flagged with nonzero union or overlap");

endmodule

[rtl/box_intersection_over_union.sv]
`timescale 1ns / 1ps
// top level of the box intersection-over-union pipeline
// depends on biou_pkg, biou_stream_if, biou_geom and biou_div
//
//  channel  | dir | payload                        | transfer when
//  ---------+-----+--------------------------------+----------------------
//  i_pair   | in  | two boxes: x, y, width, height | valid && ready
//  o_iou    | out | overlap_ratio, empty_union     | valid && ready
//
// one box pair per cycle sustained while o_iou is ready; the path runs through three
// geometry stages, a divisor setup stage, the restoring divider stages retiring up to two
// quotient bits per stage, and the output register.
// reset clears only the valid bits of every stage; payload registers are not reset.
// a stall on o_iou backs up stage by stage: a stage loads whenever it is empty
// or the stage after it moves, so bubbles collapse and nothing is dropped or repeated.
module box_intersection_over_union #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 15
) (
    input logic            i_clk,
    input logic            i_rst_n,
    biou_stream_if.sink    i_pair,
    biou_stream_if.source  o_iou
);

    // link between the geometry front end and the divider
    logic                 geom_valid;
    logic                 div_ready;
    biou_pkg::t_area_pair geom_area;

    // result side of the divider before it reaches the output channel
    logic                  res_valid;
    biou_pkg::t_iou_result res_data;

    // overlap edges, lengths and areas
    biou_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pair.valid),
        .o_ready (i_pair.ready),
        .i_pair  (i_pair.data),
        .o_valid (geom_valid),
        .i_ready (div_ready),
        .o_area  (geom_area)
    );

    // union, fixed-point quotient, saturation and empty flag
    biou_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (geom_valid),
        .o_ready  (div_ready),
        .i_area   (geom_area),
        .o_valid  (res_valid),
        .i_ready  (o_iou.ready),
        .o_result (res_data)
    );

    // the divider's output register drives the channel directly
    assign o_iou.valid = res_valid;
    assign o_iou.data  = res_data;

endmodule
